@@ sv/tccw_pkg.sv @@
package tccw_pkg;

  // Input transaction modes
  localparam logic [1:0] MODE_PUT      = 2'd0;
  localparam logic [1:0] MODE_MOVE     = 2'd1;
  localparam logic [1:0] MODE_MOVE_PUT = 2'd2;

  // Newline code point
  localparam logic [20:0] NEWLINE_CODE = 21'd10;

  // Clamped move targets never exceed 15 bits
  localparam int TGT_BITS = 15;

  // Depth of the command queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 8;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WRAP_ENABLE  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VIEW_WIDTH   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VIEW_HEIGHT  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_X     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Y     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TERM_WIDTH   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TERM_HEIGHT  = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DRAW_FRAME   = 3'd7;

  typedef struct packed {
    logic       wrap_enable;
    logic [7:0] view_width;
    logic [7:0] view_height;
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [7:0] term_width;
    logic [7:0] term_height;
    logic       draw_frame;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    wrap_enable:  1'b1,
    view_width:   8'd80,
    view_height:  8'd25,
    origin_x:     8'd0,
    origin_y:     8'd0,
    term_width:   8'd80,
    term_height:  8'd25,
    draw_frame:   1'b0
  };

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic [20:0]        code_point;
    logic [15:0]        attribute;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic        write_frame;
    logic [15:0] write_index;
    logic [20:0] write_char;
    logic [15:0] write_attr;
    logic [15:0] pen_col;
    logic [15:0] pen_row;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic                do_move;
    logic                do_put;
    logic                newline;
    logic [TGT_BITS-1:0] tx;
    logic [TGT_BITS-1:0] ty;
    logic [20:0]         ch;
    logic [15:0]         attr;
  } cmd_t;

endpackage

@@ sv/text_cursor_cell_writer_core.sv @@
// Pen-driven character cell writer for a clipped view of a text terminal.
// Input channel (in_valid/in_ready/in_data): one transaction per move, put
// or move-then-put. Output channel (out_valid/out_ready/out_data): exactly
// one transaction per input, carrying the optional cell write and the pen
// position after the item. Configuration (cfg_we/cfg_index/cfg_wdata) is a
// plain write port; the user must write it only while the block is idle,
// which the block itself does not enforce. A front stage classifies and
// clamps items into a two-entry queue; a back sequencer carries them out.
// Each wrap adds a pass of the bit-serial pen divider (one quotient bit per
// cycle). The back sequencer takes the next item from the queue only once
// the last result has been loaded into the output register.
// Reset clears the pen to the origin of the view, empties the queue and
// restores the register defaults. When the receiver stalls, the finished
// result holds in the output register while the queue keeps taking input;
// the block stops taking input once the queue is full.
module text_cursor_cell_writer_core
  import tccw_pkg::*;
#(
  parameter int FRAME_COUNT = 2,
  parameter int COORD_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

  cfg_t cfg_r;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_in;
  cmd_t q_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WRAP_ENABLE:  cfg_r.wrap_enable  <= cfg_wdata[0];
        CFG_VIEW_WIDTH:   cfg_r.view_width   <= cfg_wdata;
        CFG_VIEW_HEIGHT:  cfg_r.view_height  <= cfg_wdata;
        CFG_ORIGIN_X:     cfg_r.origin_x     <= cfg_wdata;
        CFG_ORIGIN_Y:     cfg_r.origin_y     <= cfg_wdata;
        CFG_TERM_WIDTH:   cfg_r.term_width   <= cfg_wdata;
        CFG_TERM_HEIGHT:  cfg_r.term_height  <= cfg_wdata;
        CFG_DRAW_FRAME:   cfg_r.draw_frame   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept and classify
  tccw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  // Command queue
  tccw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Back: pen update, clipping and result register
  tccw_back #(
    .FRAME_COUNT (FRAME_COUNT),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_cmd     (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/tccw_front.sv @@
module tccw_front
  import tccw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  // Take a transaction whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Decode mode and clamp negative targets to zero
  always_comb begin
    q_cmd = '0;
    case (in_data.mode)
      MODE_PUT: begin
        q_cmd.do_put = 1'b1;
      end
      MODE_MOVE: begin
        q_cmd.do_move = 1'b1;
      end
      MODE_MOVE_PUT: begin
        q_cmd.do_move = 1'b1;
        q_cmd.do_put  = 1'b1;
      end
      default: begin
        // unused mode: item passes through with no effect
      end
    endcase
    q_cmd.newline = (in_data.code_point == NEWLINE_CODE);
    q_cmd.tx      = in_data.target_x[15] ? '0 : in_data.target_x[TGT_BITS-1:0];
    q_cmd.ty      = in_data.target_y[15] ? '0 : in_data.target_y[TGT_BITS-1:0];
    q_cmd.ch      = in_data.code_point;
    q_cmd.attr    = in_data.attribute;
  end

  // Pushes only ever happen with room in the queue
  ap_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> in_ready)
    else $error("push into full queue");

endmodule

@@ sv/tccw_fifo.sv @@
module tccw_fifo
  import tccw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ sv/tccw_div.sv @@
module tccw_div #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [7:0]   divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [7:0]   remainder
);

  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  dvd_r;
  logic [7:0]    rem_r;
  logic [7:0]    dvs_r;
  logic [8:0]    shifted;
  logic [8:0]    diff;
  logic          q_bit;
  logic [7:0]    rem_nxt;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    shifted = {rem_r, dvd_r[W-1]};
    diff    = shifted - {1'b0, dvs_r};
    q_bit   = (shifted >= {1'b0, dvs_r});
    rem_nxt = q_bit ? diff[7:0] : shifted[7:0];
  end

  // Quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CW'(W - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[W-2:0], q_bit};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

  ap_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("remainder not below divisor");

endmodule

@@ sv/tccw_back.sv @@
module tccw_back
  import tccw_pkg::*;
#(
  parameter int FRAME_COUNT = 2,
  parameter int COORD_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int EW = (COORD_BITS > TGT_BITS) ? COORD_BITS : TGT_BITS;
  localparam int PW = COORD_BITS + 16;
  localparam logic [EW-1:0] CMAX_EXT = EW'({COORD_BITS{1'b1}});

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PUT  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]            state_r;
  cmd_t                  cmd_r;
  logic                  put_pend_r;
  logic [COORD_BITS-1:0] pen_x_r;
  logic [COORD_BITS-1:0] pen_y_r;
  logic                  wr_valid_r;
  logic                  wr_frame_r;
  logic [15:0]           wr_index_r;
  logic [20:0]           wr_char_r;
  logic [15:0]           wr_attr_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic                  div_start;
  logic                  div_done;
  logic [COORD_BITS-1:0] div_quo;
  logic [7:0]            div_rem;

  logic                  need_wrap;
  logic                  in_view;
  logic [8:0]            cx;
  logic [8:0]            cy;
  logic                  in_term;
  logic [15:0]           cell_prod;
  logic [15:0]           cell_index;
  logic [COORD_BITS:0]   x_inc;
  logic [COORD_BITS:0]   y_inc;
  logic [COORD_BITS:0]   y_wrap;
  logic [COORD_BITS-1:0] x_inc_sat;
  logic [COORD_BITS-1:0] y_inc_sat;
  logic [COORD_BITS-1:0] y_wrap_sat;
  logic                  frame_sel;
  logic                  out_free;
  logic                  out_load;
  logic [PW-1:0]         px_ext;
  logic [PW-1:0]         py_ext;

  // Saturate a clamped target into the pen range
  function automatic logic [COORD_BITS-1:0] clamp_max(input logic [TGT_BITS-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    if (e > CMAX_EXT) begin
      clamp_max = '1;
    end else begin
      clamp_max = COORD_BITS'(e);
    end
  endfunction

  // Wrap check, view and terminal clipping, cell address
  always_comb begin
    need_wrap  = cfg.wrap_enable && (cfg.view_width != '0) &&
                 (pen_x_r >= COORD_BITS'(cfg.view_width));
    in_view    = (pen_x_r < COORD_BITS'(cfg.view_width)) &&
                 (pen_y_r < COORD_BITS'(cfg.view_height));
    cx         = {1'b0, pen_x_r[7:0]} + {1'b0, cfg.origin_x};
    cy         = {1'b0, pen_y_r[7:0]} + {1'b0, cfg.origin_y};
    in_term    = (cx < {1'b0, cfg.term_width}) && (cy < {1'b0, cfg.term_height});
    cell_prod  = {8'b0, cy[7:0]} * {8'b0, cfg.term_width};
    cell_index = cell_prod + {8'b0, cx[7:0]};
    frame_sel  = (FRAME_COUNT > 1) ? cfg.draw_frame : 1'b0;
  end

  // Saturating pen arithmetic
  always_comb begin
    x_inc      = {1'b0, pen_x_r} + 1'b1;
    y_inc      = {1'b0, pen_y_r} + 1'b1;
    y_wrap     = {1'b0, pen_y_r} + {1'b0, div_quo};
    x_inc_sat  = x_inc[COORD_BITS] ? '1 : x_inc[COORD_BITS-1:0];
    y_inc_sat  = y_inc[COORD_BITS] ? '1 : y_inc[COORD_BITS-1:0];
    y_wrap_sat = y_wrap[COORD_BITS] ? '1 : y_wrap[COORD_BITS-1:0];
  end

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign div_start = (state_r == S_CHK) && need_wrap;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (state_r == S_OUT) && out_free;
  assign px_ext    = PW'(pen_x_r);
  assign py_ext    = PW'(pen_y_r);

  // Pen division unit for wrapping
  tccw_div #(
    .W (COORD_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (pen_x_r),
    .divisor   (cfg.view_width),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Command sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      put_pend_r  <= 1'b0;
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      wr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            cmd_r      <= q_cmd;
            put_pend_r <= q_cmd.do_put;
            wr_valid_r <= 1'b0;
            wr_frame_r <= 1'b0;
            wr_index_r <= '0;
            wr_char_r  <= '0;
            wr_attr_r  <= '0;
            if (q_cmd.do_move) begin
              pen_x_r <= clamp_max(q_cmd.tx);
              pen_y_r <= clamp_max(q_cmd.ty);
              state_r <= S_CHK;
            end else if (q_cmd.do_put) begin
              state_r <= S_PUT;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_PUT: begin
          put_pend_r <= 1'b0;
          if (cmd_r.newline) begin
            pen_x_r <= '0;
            pen_y_r <= y_inc_sat;
            state_r <= S_OUT;
          end else begin
            if (in_view && in_term) begin
              wr_valid_r <= 1'b1;
              wr_frame_r <= frame_sel;
              wr_index_r <= cell_index;
              wr_char_r  <= cmd_r.ch;
              wr_attr_r  <= cmd_r.attr;
            end
            pen_x_r <= x_inc_sat;
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          if (need_wrap) begin
            state_r <= S_DIV;
          end else if (put_pend_r) begin
            state_r <= S_PUT;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pen_x_r <= COORD_BITS'(div_rem);
            pen_y_r <= y_wrap_sat;
            state_r <= put_pend_r ? S_PUT : S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_r.write_valid <= wr_valid_r;
            out_r.write_frame <= wr_frame_r;
            out_r.write_index <= wr_index_r;
            out_r.write_char  <= wr_char_r;
            out_r.write_attr  <= wr_attr_r;
            out_r.pen_col     <= px_ext[15:0];
            out_r.pen_row     <= py_ext[15:0];
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ap_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  ap_wrap_in_view: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && div_done |=> (pen_x_r < COORD_BITS'(cfg.view_width)))
    else $error("pen column not inside view after wrap");

  ap_no_newline_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.write_valid |-> (out_r.write_char != NEWLINE_CODE))
    else $error("newline issued as a cell write");

endmodule

@@ dv/text_cursor_cell_writer_core_test.sv @@
`timescale 1ns / 1ps

module text_cursor_cell_writer_core_test;
  import tccw_pkg::*;

  // Mode code that the block leaves unused
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 64;
  localparam int unsigned PRINT_CAP    = 50;
  localparam int unsigned IDLE_PERCENT = 31;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  // Pen model and the register copy it works from
  logic [15:0] pen_x = '0;
  logic [15:0] pen_y = '0;
  cfg_t        view_cfg = CFG_RESET;

  out_item_t   pen_results_due[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned writes_seen = 0;
  int unsigned settings_applied = 0;

  // Idle controls, owned by the test sequence
  bit          tx_stall_enable = 1'b1;
  bit          rx_stall_enable = 1'b1;
  int unsigned hold_requests = 0;
  // Owned by the receiver
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;

  text_cursor_cell_writer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               pen_results_due.size());
      $display("text_cursor_cell_writer_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Pen model
  // ---------------------------------------------------------------------

  function automatic logic [15:0] sat_sum(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // Negative targets clamp to zero
  function automatic logic [15:0] clamp_target(logic signed [15:0] t);
    return t[15] ? 16'd0 : {1'b0, t[14:0]};
  endfunction

  function automatic void wrap_pen();
    logic [15:0] vw;
    vw = {8'd0, view_cfg.view_width};
    if (view_cfg.wrap_enable && vw != 16'd0 && pen_x >= vw) begin
      pen_y = sat_sum(pen_y, pen_x / vw);
      pen_x = pen_x % vw;
    end
  endfunction

  // Advances the pen for one transaction and returns the resulting cell write
  function automatic out_item_t step_pen(in_item_t item);
    out_item_t res;
    int        cx;
    int        cy;
    bit        moves;
    bit        puts;
    res = '0;
    moves = (item.mode == MODE_MOVE) || (item.mode == MODE_MOVE_PUT);
    puts  = (item.mode == MODE_PUT)  || (item.mode == MODE_MOVE_PUT);
    if (moves) begin
      pen_x = clamp_target(item.target_x);
      pen_y = clamp_target(item.target_y);
      wrap_pen();
    end
    if (puts) begin
      if (item.code_point == NEWLINE_CODE) begin
        pen_x = 16'd0;
        pen_y = sat_sum(pen_y, 16'd1);
      end else begin
        if (pen_x < view_cfg.view_width && pen_y < view_cfg.view_height) begin
          cx = int'(pen_x) + int'(view_cfg.origin_x);
          cy = int'(pen_y) + int'(view_cfg.origin_y);
          if (cx < int'(view_cfg.term_width) && cy < int'(view_cfg.term_height)) begin
            res.write_valid = 1'b1;
            res.write_frame = view_cfg.draw_frame;
            res.write_index = 16'(cy * int'(view_cfg.term_width) + cx);
            res.write_char  = item.code_point;
            res.write_attr  = item.attribute;
          end
        end
        pen_x = sat_sum(pen_x, 16'd1);
        wrap_pen();
      end
    end
    res.pen_col = pen_x;
    res.pen_row = pen_y;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_cell_write(out_item_t got);
    out_item_t want;
    if (pen_results_due.size() == 0) begin
      report_mismatch("result with nothing due, pen_col", got.pen_col, 0);
      return;
    end
    want = pen_results_due.pop_front();
    results_seen++;
    if (want.write_valid) writes_seen++;
    if (got.write_valid !== want.write_valid)
      report_mismatch("write_valid", got.write_valid, want.write_valid);
    if (got.write_frame !== want.write_frame)
      report_mismatch("write_frame", got.write_frame, want.write_frame);
    if (got.write_index !== want.write_index)
      report_mismatch("write_index", got.write_index, want.write_index);
    if (got.write_char !== want.write_char)
      report_mismatch("write_char", got.write_char, want.write_char);
    if (got.write_attr !== want.write_attr)
      report_mismatch("write_attr", got.write_attr, want.write_attr);
    if (got.pen_col !== want.pen_col)
      report_mismatch("pen_col", got.pen_col, want.pen_col);
    if (got.pen_row !== want.pen_row)
      report_mismatch("pen_row", got.pen_row, want.pen_row);
  endtask

  // Receiver: check each transaction, then choose next cycle's ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_cell_write(out_data);
      if (hold_requests != hold_served) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_stall_enable && $urandom_range(99) < IDLE_PERCENT) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offers one transaction; leaves valid high on return
  task automatic send_item(in_item_t item);
    if (tx_stall_enable && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pen_results_due.push_back(step_pen(item));
    items_sent++;
  endtask

  // Drops valid and waits for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pen_results_due.size() != 0);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all eight registers while the block is idle
  task automatic apply_config(cfg_t c);
    drain_results();
    @(posedge clk);
    cfg_write(CFG_WRAP_ENABLE,  {7'd0, c.wrap_enable});
    cfg_write(CFG_VIEW_WIDTH,   c.view_width);
    cfg_write(CFG_VIEW_HEIGHT,  c.view_height);
    cfg_write(CFG_ORIGIN_X,     c.origin_x);
    cfg_write(CFG_ORIGIN_Y,     c.origin_y);
    cfg_write(CFG_TERM_WIDTH,   c.term_width);
    cfg_write(CFG_TERM_HEIGHT,  c.term_height);
    cfg_write(CFG_DRAW_FRAME,   {7'd0, c.draw_frame});
    view_cfg = c;
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic in_item_t make_item(logic [1:0] mode, logic [15:0] x, logic [15:0] y,
                                         logic [20:0] ch, logic [15:0] attr);
    in_item_t it;
    it.mode       = mode;
    it.target_x   = x;
    it.target_y   = y;
    it.code_point = ch;
    it.attribute  = attr;
    return it;
  endfunction

  // Mostly near the view, sometimes negative or anywhere
  function automatic logic [15:0] rand_target();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return 16'($urandom_range(0, 300));
    if (pick < 85) return {1'b1, 15'($urandom)};
    return 16'($urandom);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)      it.mode = MODE_PUT;
    else if (pick < 60) it.mode = MODE_MOVE;
    else if (pick < 95) it.mode = MODE_MOVE_PUT;
    else                it.mode = MODE_UNUSED;
    it.target_x = rand_target();
    it.target_y = rand_target();
    pick = $urandom_range(99);
    if (pick < 8)       it.code_point = NEWLINE_CODE;
    else if (pick < 22) it.code_point = 21'($urandom);
    else                it.code_point = 21'($urandom_range(32, 126));
    it.attribute = 16'($urandom);
    return it;
  endfunction

  function automatic logic [7:0] pick_byte(int unsigned lo, int unsigned hi);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8)  return 8'd0;
    if (pick < 16) return 8'hFF;
    return 8'($urandom_range(lo, hi));
  endfunction

  function automatic cfg_t rand_view_cfg();
    cfg_t c;
    c.wrap_enable  = ($urandom_range(99) < 75);
    c.view_width   = pick_byte(1, 100);
    c.view_height  = pick_byte(1, 60);
    c.origin_x     = pick_byte(0, 20);
    c.origin_y     = pick_byte(0, 20);
    c.term_width   = pick_byte(10, 120);
    c.term_height  = pick_byte(5, 60);
    c.draw_frame   = 1'($urandom);
    return c;
  endfunction

  task automatic send_random(int unsigned count);
    repeat (count) send_item(rand_item());
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes, every mode, newline and clamping under reset settings
  task automatic test_directed();
    send_item(make_item(MODE_PUT, 16'd0, 16'd0, 21'h41, 16'hFFFF));
    send_item(make_item(MODE_PUT, 16'd0, 16'd0, 21'h1FFFFF, 16'h0000));
    send_item(make_item(MODE_MOVE, 16'd79, 16'd24, 21'd0, 16'd0));
    send_item(make_item(MODE_PUT, 16'd0, 16'd0, 21'h5A, 16'h1234));
    send_item(make_item(MODE_PUT, 16'd0, 16'd0, 21'h5B, 16'h4321));
    send_item(make_item(MODE_PUT, 16'hFFFF, 16'hFFFF, NEWLINE_CODE, 16'hFFFF));
    send_item(make_item(MODE_MOVE, 16'hFFFF, 16'h8000, 21'h1FFFFF, 16'hFFFF));
    send_item(make_item(MODE_MOVE_PUT, 16'h8000, 16'd5, 21'h7A, 16'h00FF));
    send_item(make_item(MODE_MOVE_PUT, 16'h7FFF, 16'h7FFF, 21'h71, 16'hFF00));
    send_item(make_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 21'h1FFFFF, 16'hFFFF));
    send_item(make_item(MODE_MOVE, 16'h5555, 16'h2AAA, 21'h0AAAAA, 16'hAAAA));
    send_item(make_item(MODE_MOVE_PUT, 16'd3, 16'd3, NEWLINE_CODE, 16'h5555));
    send_item(make_item(MODE_PUT, 16'd0, 16'd0, 21'd0, 16'hAAAA));
    send_item(make_item(MODE_MOVE_PUT, 16'd40, 16'd12, 21'h155555, 16'h5555));
    send_item(make_item(MODE_MOVE_PUT, 16'hAAAA, 16'h5555, 21'h20, 16'd0));
    send_item(make_item(MODE_UNUSED, 16'd0, 16'd0, 21'd0, 16'd0));
    send_item(make_item(MODE_MOVE_PUT, 16'd0, 16'd24, 21'h10FFFF, 16'h8001));
    send_item(make_item(MODE_PUT, 16'd0, 16'd0, NEWLINE_CODE, 16'd0));
  endtask

  // Width of one forces wraps that push the row to saturation
  task automatic test_saturation();
    cfg_t c;
    c = CFG_RESET;
    c.view_width = 8'd1;
    apply_config(c);
    send_item(make_item(MODE_MOVE, 16'h7FFF, 16'h7FFF, 21'd0, 16'd0));
    send_item(make_item(MODE_PUT, 16'd0, 16'd0, 21'h61, 16'h0001));
    send_item(make_item(MODE_PUT, 16'd0, 16'd0, 21'h62, 16'h0002));
    send_item(make_item(MODE_PUT, 16'd0, 16'd0, NEWLINE_CODE, 16'd0));
    send_item(make_item(MODE_MOVE_PUT, 16'd0, 16'd0, 21'h63, 16'h0003));
    c.view_width = 8'd255;
    apply_config(c);
    send_item(make_item(MODE_MOVE_PUT, 16'h7FFF, 16'd0, 21'h64, 16'h0004));
  endtask

  // Each register at its limits, with random traffic in each setting
  task automatic test_register_extremes();
    cfg_t c;
    c = '0;
    apply_config(c);
    send_random(35);
    c = '1;
    apply_config(c);
    send_random(35);
    c = CFG_RESET;
    c.view_width = 8'd0;
    apply_config(c);
    send_random(35);
    c = CFG_RESET;
    c.wrap_enable = 1'b0;
    apply_config(c);
    send_random(35);
    c = CFG_RESET;
    c.origin_x    = 8'hFF;
    c.origin_y    = 8'hFF;
    c.term_width  = 8'hFF;
    c.term_height = 8'hFF;
    apply_config(c);
    send_random(35);
    c = CFG_RESET;
    c.view_width   = 8'd1;
    c.view_height  = 8'hFF;
    c.term_width   = 8'hFF;
    c.term_height  = 8'hFF;
    c.draw_frame   = 1'b1;
    apply_config(c);
    send_random(35);
    c = CFG_RESET;
    c.origin_x     = 8'd10;
    c.origin_y     = 8'd5;
    c.draw_frame   = 1'b1;
    apply_config(c);
    send_random(35);
  endtask

  // Receiver holds off while the sender keeps pushing, so input stalls
  task automatic test_output_hold_off();
    apply_config(CFG_RESET);
    tx_stall_enable = 1'b0;
    hold_requests++;
    send_random(30);
    tx_stall_enable = 1'b1;
  endtask

  // Sender stops until everything is back, then resumes
  task automatic test_drain_pause();
    send_random(40);
    drain_results();
    send_random(40);
  endtask

  // Random register settings; one phase runs with no idling on either side
  task automatic test_random_settings();
    for (int phase = 0; phase < 10; phase++) begin
      apply_config(rand_view_cfg());
      tx_stall_enable = (phase != 4);
      rx_stall_enable = (phase != 4);
      send_random(70);
    end
    tx_stall_enable = 1'b1;
    rx_stall_enable = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_register_extremes();
    test_output_hold_off();
    test_drain_pause();
    test_random_settings();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pen_results_due.size() != 0)
      report_mismatch("results never delivered", pen_results_due.size(), 0);
    $display("covered %0d transactions (%0d cell writes) over %0d register settings,",
             items_sent, writes_seen, settings_applied);
    $display("a %0d-cycle output hold-off and a full drain pause; %0d mismatches",
             HOLD_CYCLES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("text_cursor_cell_writer_core regression: pass");
    end else begin
      $display("text_cursor_cell_writer_core regression: fail");
    end
    $finish;
  end

endmodule
